// ===== hdl/mma_pkg.sv =====
// Shared types and constants for the multichannel moving average unit.
package mma_pkg;

    localparam int TEMP_W       = 24;
    localparam int CHAN_W       = 3;
    localparam int CHANNELS_DEF = 8;
    localparam int DEPTH_DEF    = 8;
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic [CHAN_W-1:0]        chan;
        logic signed [TEMP_W-1:0] temp_sample;
        logic                     sample_ok;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0]        out_chan;
        logic signed [TEMP_W-1:0] avg_temp;
        logic                     was_updated;
    } t_out_word;

    // Classified sample passed from the front end to the accumulator.
    typedef struct packed {
        logic [CHAN_W-1:0]        chan;
        logic signed [TEMP_W-1:0] sample;
        logic signed [TEMP_W-1:0] oldest;
        logic                     in_range;
        logic                     update;
        logic                     first;
    } t_work;

endpackage

// ===== hdl/mma_front.sv =====
// Front end: channel bookkeeping, window store and the oldest-entry lookup.
module mma_front #(
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
    parameter int DEPTH    = mma_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mma_pkg::t_in_word i_wr_data,
    output logic              o_full,
    output logic              o_q_push,
    output mma_pkg::t_work    o_q_data,
    input  logic              i_q_full
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W    = $clog2(DEPTH);
    localparam int EW_W     = $clog2(DEPTH + 1);
    localparam int ENTRIES  = CHANNELS * DEPTH;
    localparam int ADDR_W   = $clog2(ENTRIES);

    logic [POS_W-1:0]                 r_pos [CHANNELS];
    logic [EW_W-1:0]                  r_ew [CHANNELS];
    logic [CHANNELS-1:0]              r_started;
    logic signed [mma_pkg::TEMP_W-1:0] r_fill [CHANNELS];
    logic signed [mma_pkg::TEMP_W-1:0] r_mem [ENTRIES];
    logic signed [mma_pkg::TEMP_W-1:0] r_rd_data;

    logic           r_s1_valid;
    logic           r_s1_use_fill;
    mma_pkg::t_work r_s1;

    logic                              accept;
    logic                              in_range;
    logic                              upd;
    logic [CH_IDX_W-1:0]               ch;
    logic [POS_W-1:0]                  pos;
    logic [EW_W-1:0]                   ew;
    logic                              first;
    logic                              use_fill;
    logic signed [mma_pkg::TEMP_W-1:0] fill_val;
    logic [POS_W-1:0]                  n_pos;
    logic [EW_W-1:0]                   n_ew;
    logic [ADDR_W-1:0]                 addr;

    assign o_full   = r_s1_valid && i_q_full;
    assign o_q_push = r_s1_valid && !i_q_full;
    assign accept   = i_push && !o_full;

    assign in_range = 32'(i_wr_data.chan) < 32'(CHANNELS);
    assign upd      = accept && in_range && i_wr_data.sample_ok;
    assign ch       = CH_IDX_W'(i_wr_data.chan);
    assign pos      = r_pos[ch];
    assign ew       = r_ew[ch];
    assign first    = !r_started[ch];
    // slots not yet written this run still hold the fill value
    assign use_fill = first || !(EW_W'(pos) < ew);
    assign fill_val = first ? i_wr_data.temp_sample : r_fill[ch];
    assign n_pos    = (pos == POS_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
    assign addr     = ADDR_W'(ch) * ADDR_W'(DEPTH) + ADDR_W'(pos);

    always_comb begin
        if (first) begin
            n_ew = EW_W'(1);
        end else if (ew < EW_W'(DEPTH)) begin
            n_ew = ew + 1'b1;
        end else begin
            n_ew = ew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_pos[i] <= '0;
                r_ew[i]  <= '0;
            end
        end else if (upd) begin
            r_started[ch] <= 1'b1;
            r_pos[ch]     <= n_pos;
            r_ew[ch]      <= n_ew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd && first) begin
            r_fill[ch] <= i_wr_data.temp_sample;
        end
    end

    // read-before-write on the same slot returns the entry being replaced
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[addr];
            if (upd) begin
                r_mem[addr] <= i_wr_data.temp_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_q_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.chan     <= i_wr_data.chan;
            r_s1.sample   <= i_wr_data.temp_sample;
            r_s1.oldest   <= fill_val;
            r_s1.in_range <= in_range;
            r_s1.update   <= upd;
            r_s1.first    <= first;
            r_s1_use_fill <= use_fill;
        end
    end

    always_comb begin
        o_q_data = r_s1;
        if (!r_s1_use_fill) begin
            o_q_data.oldest = r_rd_data;
        end
    end

endmodule

// ===== hdl/mma_queue.sv =====
// Short word queue between the front end and the accumulator.
module mma_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mma_pkg::t_work i_data,
    output logic           o_full,
    output logic           o_valid,
    output mma_pkg::t_work o_data,
    input  logic           i_pop
);

    localparam int QD    = mma_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);

    mma_pkg::t_work   r_mem [QD];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(QD);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/mma_back.sv =====
// Accumulator: running sums, floor average with saturation, result register.
module mma_back #(
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
    parameter int DEPTH    = mma_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  mma_pkg::t_work     i_q_data,
    output logic               o_q_pop,
    output logic               o_empty,
    output mma_pkg::t_out_word o_rd_data,
    input  logic               i_pop
);

    localparam int TW       = mma_pkg::TEMP_W;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W    = TW + $clog2(DEPTH);
    localparam int SHIFT    = $clog2(DEPTH + 1) - 1;
    localparam logic signed [SUM_W+1:0] DEPTH_W = (SUM_W + 2)'(DEPTH);

    logic signed [SUM_W-1:0] r_sum [CHANNELS];
    logic signed [TW-1:0]    r_last [CHANNELS];
    logic                    r_out_valid;
    mma_pkg::t_out_word      r_out;

    logic [CH_IDX_W-1:0]     ch;
    logic signed [SUM_W+1:0] samp_w;
    logic signed [SUM_W+1:0] old_w;
    logic signed [SUM_W+1:0] base_w;
    logic signed [SUM_W+1:0] wide;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] quot;
    logic signed [TW-1:0]    n_avg;
    mma_pkg::t_out_word      n_out;

    assign o_q_pop   = i_q_valid && (!r_out_valid || i_pop);
    assign o_empty   = !r_out_valid;
    assign o_rd_data = r_out;

    assign ch     = CH_IDX_W'(i_q_data.chan);
    assign samp_w = (SUM_W + 2)'(i_q_data.sample);
    assign old_w  = (SUM_W + 2)'(i_q_data.oldest);
    // first sample: whole window is the sample, and oldest equals it
    assign base_w = i_q_data.first ? samp_w * DEPTH_W : (SUM_W + 2)'(r_sum[ch]);
    assign wide   = base_w + samp_w - old_w;
    assign n_sum  = wide[SUM_W-1:0];
    assign quot   = n_sum >>> SHIFT;

    always_comb begin
        if ((quot[SUM_W-1:TW-1] == '0) || (quot[SUM_W-1:TW-1] == '1)) begin
            n_avg = quot[TW-1:0];
        end else if (quot[SUM_W-1]) begin
            n_avg = {1'b1, {(TW - 1){1'b0}}};
        end else begin
            n_avg = {1'b0, {(TW - 1){1'b1}}};
        end
    end

    always_comb begin
        n_out.out_chan    = i_q_data.chan;
        n_out.was_updated = i_q_data.update;
        if (!i_q_data.in_range) begin
            n_out.avg_temp = '0;
        end else if (i_q_data.update) begin
            n_out.avg_temp = n_avg;
        end else begin
            n_out.avg_temp = r_last[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i]  <= '0;
                r_last[i] <= '0;
            end
        end else if (o_q_pop && i_q_data.update) begin
            r_sum[ch]  <= n_sum;
            r_last[ch] <= n_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/multichannel_moving_average_unit.sv =====
// Top level of the multichannel moving average unit.
//
// Input side is a queue write port: a word (channel, sample, status flag) is
// taken at a clock edge with push high and full low. Result side is a queue
// read port: while empty is low the oldest result sits on o_rd_data, and it
// leaves at an edge with pop high. Every input word yields exactly one result.
// A word is taken every cycle while full is low; the front end updates the
// channel's ring position and reads and writes the window store at the edge
// that takes the word, so the same channel may arrive on consecutive cycles.
// A word passes through the front-end stage register and the two-word queue
// to the accumulator's result register; when pop stays low the queue fills
// and full rises once four words are in flight.
// Reset clears every channel to not yet started, with zero sums and averages.
// The window store itself is not cleared: a channel's first valid sample
// fills the window logically, so reset takes effect at once.
module multichannel_moving_average_unit #(
    parameter int CHANNELS = mma_pkg::CHANNELS_DEF,
    parameter int DEPTH    = mma_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  mma_pkg::t_in_word  i_wr_data,
    output logic               full,
    output logic               empty,
    output mma_pkg::t_out_word o_rd_data,
    input  logic               pop
);

    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    mma_pkg::t_work q_in;
    mma_pkg::t_work q_out;

    mma_front #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (i_wr_data),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_data  (q_in),
        .i_q_full  (q_full)
    );

    mma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    mma_back #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .o_rd_data (o_rd_data),
        .i_pop     (pop)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && !q_valid))
        else $error("accumulator popped an empty queue");

    a_update_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rd_data.was_updated) |-> (32'(o_rd_data.out_chan) < 32'(CHANNELS)))
        else $error("update reported on a channel beyond range");

    a_idle_chan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (32'(o_rd_data.out_chan) >= 32'(CHANNELS))) |->
            (o_rd_data.avg_temp == '0))
        else $error("nonzero average on a channel beyond range");
`endif

endmodule
